// ===== rtl/core/thb_pkg.sv =====
`default_nettype none
package thb_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;

  // Q16 distance ratio, 0..65536
  localparam int T_BITS = 16;
  localparam int TW     = T_BITS + 1;

  // cosine polynomial operands: u in Q30, coefficients below 2^31
  localparam int UW  = 31;
  localparam int PW  = 31;
  localparam int PRW = UW + PW;
  localparam int COS_STEPS = 5;

  localparam logic [PW-1:0] COS_C1  = 31'd1324675879;
  localparam logic [PW-1:0] COS_C2  = 31'd272375560;
  localparam logic [PW-1:0] COS_C3  = 31'd22401992;
  localparam logic [PW-1:0] COS_C4  = 31'd987048;
  localparam logic [PW-1:0] COS_C5  = 31'd27060;
  localparam logic [PW-1:0] ONE_Q30 = 31'd1073741824;

  typedef enum logic [1:0] {
    MODE_ROUND  = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_FLAT   = 2'd2,
    MODE_UNUSED = 2'd3
  } brush_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Z = 3'd1,
    CFG_RADIUS   = 3'd2,
    CFG_GAIN     = 3'd3,
    CFG_MODE     = 3'd4,
    CFG_RAISE    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic last;
    logic in_circle;
    logic in_square;
  } thb_flags_t;

  localparam int FLAGS_W = $bits(thb_flags_t);

  // coefficient subtracted from in step k of the Horner chain
  function automatic logic [PW-1:0] cos_coef(input int k);
    logic [PW-1:0] c;
    case (k)
      0: c = COS_C4;
      1: c = COS_C3;
      2: c = COS_C2;
      3: c = COS_C1;
      default: c = ONE_Q30;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/thb_vtx_if.sv =====
`default_nettype none
interface thb_vtx_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_z;
  logic signed [COORD_WIDTH-1:0] vertex_height;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_z, vertex_height, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_z, vertex_height, last_vertex, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/thb_res_if.sv =====
`default_nettype none
interface thb_res_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] new_height;
  logic                          touched;
  logic                          sweep_end;

  modport source (output valid, new_height, touched, sweep_end, input ready);
  modport sink (input valid, new_height, touched, sweep_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/thb_cfg_if.sv =====
`default_nettype none
interface thb_cfg_if
  import thb_pkg::*;
#(
  parameter int COORD_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [COORD_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/thb_sqrt_pipe.sv =====
`default_nettype none
module thb_sqrt_pipe
  import thb_pkg::*;
#(
  parameter int W     = 24,
  parameter int TAG_W = 27
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [2*W-1:0]   radicand,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_valid,
  output logic [W-1:0]          root,
  output logic [TAG_W-1:0]      out_tag
);

  logic [2*W-1:0]   rad  [0:W];
  logic [W+1:0]     rem  [0:W];
  logic [W-1:0]     rt   [0:W];
  logic [TAG_W-1:0] tag  [0:W];
  logic             vld  [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad[0] <= radicand;
      rem[0] <= '0;
      rt[0]  <= '0;
      tag[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W+1:0] rem_sh;
    logic [W+1:0] trial;
    logic         ge;

    // bring down the next two radicand bits, try root digit one
    assign rem_sh = {rem[i][W-1:0], rad[i][2*W-1:2*W-2]};
    assign trial  = {rt[i], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1] <= {rad[i][2*W-3:0], 2'b00};
        rem[i+1] <= ge ? rem_sh - trial : rem_sh;
        rt[i+1]  <= {rt[i][W-2:0], ge};
        tag[i+1] <= tag[i];
      end
    end
  end

  assign out_valid = vld[W];
  assign root      = rt[W];
  assign out_tag   = tag[W];

endmodule
`default_nettype wire

// ===== rtl/core/thb_div_pipe.sv =====
`default_nettype none
module thb_div_pipe
  import thb_pkg::*;
#(
  parameter int W     = 23,
  parameter int TAG_W = 27
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [W-1:0]     dist_val,
  input  wire logic [W-1:0]     radius,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_valid,
  output logic [TW-1:0]         ratio,
  output logic [TAG_W-1:0]      out_tag
);

  // quotient of dist_val * 2^T_BITS / radius, one bit per rank; exact only while dist_val < 2 * radius
  logic [W-1:0]     rem [0:T_BITS];
  logic [TW-1:0]    q   [0:T_BITS];
  logic [TAG_W-1:0] tag [0:T_BITS];
  logic             vld [0:T_BITS];
  logic             ge0;

  assign ge0 = dist_val >= radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ge0 ? dist_val - radius : dist_val;
      q[0]   <= {{(TW-1){1'b0}}, ge0};
      tag[0] <= in_tag;
    end
  end

  for (genvar k = 0; k < T_BITS; k++) begin : g_step
    logic [W:0] sh;
    logic       ge;

    assign sh = {rem[k], 1'b0};
    assign ge = sh >= {1'b0, radius};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? W'(sh - {1'b0, radius}) : sh[W-1:0];
        q[k+1]   <= {q[k][TW-2:0], ge};
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[T_BITS];
  assign ratio     = q[T_BITS];
  assign out_tag   = tag[T_BITS];

endmodule
`default_nettype wire

// ===== rtl/core/thb_cos_pipe.sv =====
`default_nettype none
module thb_cos_pipe
  import thb_pkg::*;
#(
  parameter int WEIGHT_BITS = 16,
  parameter int TAG_W       = 27
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [TW-1:0]        ratio,
  input  wire logic [TAG_W-1:0]     in_tag,
  output logic                      out_valid,
  output logic [WEIGHT_BITS:0]      weight,
  output logic [TAG_W-1:0]          out_tag
);

  localparam int RANKS = 2 * COS_STEPS + 1;

  logic [UW-1:0]    u    [0:RANKS-1];
  logic [PW-1:0]    p    [0:RANKS-1];
  logic [PRW-1:0]   prod [0:RANKS-1];
  logic [TAG_W-1:0] tag  [0:RANKS-1];
  logic             vld  [0:RANKS-1];
  logic [2*TW-1:0]  tsq;

  assign tsq = {{TW{1'b0}}, ratio} * {{TW{1'b0}}, ratio};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u[0]    <= tsq[UW+1:2];
      p[0]    <= COS_C5;
      prod[0] <= '0;
      tag[0]  <= in_tag;
    end
  end

  for (genvar k = 0; k < COS_STEPS; k++) begin : g_step
    logic [PRW-31:0] sc;

    assign sc = prod[2*k+1][PRW-1:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[2*k+1] <= 1'b0;
        vld[2*k+2] <= 1'b0;
      end else if (en) begin
        vld[2*k+1] <= vld[2*k];
        vld[2*k+2] <= vld[2*k+1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        u[2*k+1]    <= u[2*k];
        p[2*k+1]    <= p[2*k];
        prod[2*k+1] <= {{PW{1'b0}}, u[2*k]} * {{UW{1'b0}}, p[2*k]};
        tag[2*k+1]  <= tag[2*k];

        u[2*k+2]    <= u[2*k+1];
        // clamp at zero from below
        if (sc > {1'b0, cos_coef(k)}) begin
          p[2*k+2] <= '0;
        end else begin
          p[2*k+2] <= PW'({1'b0, cos_coef(k)} - sc);
        end
        prod[2*k+2] <= prod[2*k+1];
        tag[2*k+2]  <= tag[2*k+1];
      end
    end
  end

  assign out_valid = vld[RANKS-1];
  assign weight    = p[RANKS-1][30 -: (WEIGHT_BITS + 1)];
  assign out_tag   = tag[RANKS-1];

endmodule
`default_nettype wire

// ===== rtl/core/terrain_height_brush_top.sv =====
`default_nettype none
// Terrain height brush: one vertex word in on vtx, one result word out on res.
// vtx carries vertex_x, vertex_z, vertex_height and last_vertex; res returns
// new_height (saturated), touched and sweep_end in the same order.
// cfg writes brush registers by index: 0 center_x, 1 center_z, 2 brush_radius,
// 3 step_gain, 4 brush_mode, 5 raise; cfg.ready is always high. Write it only
// while the pipeline is empty and allow rr to update before the next vertex.
// Throughput: one vertex per cycle while res does not stall. From accept to
// res.valid the vertex passes rank a, rank b, the one-bit-per-rank square
// root (COORD_WIDTH + 1 ranks), the 17-rank divider for d/r, the 11-rank
// cosine polynomial, the gain rank and the output rank.
// When res stalls the whole pipeline holds and vtx.ready drops; the final
// rank is the output register, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: centre at
// origin, radius 1.0, gain 0, round mode, raise.
module terrain_height_brush_top
  import thb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  thb_vtx_if.sink   vtx,
  thb_res_if.source res,
  thb_cfg_if.sink   cfg
);

  localparam int C     = COORD_WIDTH;
  localparam int TAG_W = C + FLAGS_W;

  // configuration
  logic signed [C-1:0] center_x;
  logic signed [C-1:0] center_z;
  logic [C-2:0]        brush_radius;
  logic [C-2:0]        step_gain;
  logic [1:0]          brush_mode;
  logic                raise;
  logic [2*C-3:0]      rr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_z     <= '0;
      brush_radius <= (C-1)'(1 << FRAC_BITS);
      step_gain    <= '0;
      brush_mode   <= MODE_ROUND;
      raise        <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CENTER_X: center_x     <= cfg.data;
        CFG_CENTER_Z: center_z     <= cfg.data;
        CFG_RADIUS:   brush_radius <= cfg.data[C-2:0];
        CFG_GAIN:     step_gain    <= cfg.data[C-2:0];
        CFG_MODE:     brush_mode   <= cfg.data[1:0];
        CFG_RAISE:    raise        <= cfg.data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rr <= {{(C-1){1'b0}}, brush_radius} * {{(C-1){1'b0}}, brush_radius};
  end

  logic en;
  assign en        = !res.valid || res.ready;
  assign vtx.ready = en;

  // rank a: saturated absolute offsets
  logic signed [C:0] dx;
  logic signed [C:0] dz;
  logic [C:0]        adx;
  logic [C:0]        adz;
  localparam logic [C:0] ALIM = (C+1)'(1) << (C-1);

  assign dx  = $signed({vtx.vertex_x[C-1], vtx.vertex_x}) - $signed({center_x[C-1], center_x});
  assign dz  = $signed({vtx.vertex_z[C-1], vtx.vertex_z}) - $signed({center_z[C-1], center_z});
  assign adx = dx[C] ? (C+1)'(-dx) : dx;
  assign adz = dz[C] ? (C+1)'(-dz) : dz;

  logic         va;
  logic [C-1:0] ax_a;
  logic [C-1:0] az_a;
  logic [C-1:0] h_a;
  logic         last_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= vtx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_a   <= (adx > ALIM) ? ALIM[C-1:0] : adx[C-1:0];
      az_a   <= (adz > ALIM) ? ALIM[C-1:0] : adz[C-1:0];
      h_a    <= vtx.vertex_height;
      last_a <= vtx.last_vertex;
    end
  end

  // rank b: squares and square-brush test
  logic           vb;
  logic [2*C-1:0] sqx_b;
  logic [2*C-1:0] sqz_b;
  logic           insq_b;
  logic [C-1:0]   h_b;
  logic           last_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_b  <= {{C{1'b0}}, ax_a} * {{C{1'b0}}, ax_a};
      sqz_b  <= {{C{1'b0}}, az_a} * {{C{1'b0}}, az_a};
      insq_b <= (ax_a <= {1'b0, brush_radius}) && (az_a <= {1'b0, brush_radius});
      h_b    <= h_a;
      last_b <= last_a;
    end
  end

  logic [2*C-1:0] d2;
  thb_flags_t     flags_b;

  assign d2                = sqx_b + sqz_b;
  assign flags_b.last      = last_b;
  assign flags_b.in_circle = d2 <= {2'b00, rr};
  assign flags_b.in_square = insq_b;

  logic             vs;
  logic [C-1:0]     dist_val;
  logic [TAG_W-1:0] tag_s;

  thb_sqrt_pipe #(.W(C), .TAG_W(TAG_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .radicand  (d2),
    .in_tag    ({h_b, flags_b}),
    .out_valid (vs),
    .root      (dist_val),
    .out_tag   (tag_s)
  );

  logic             vd;
  logic [TW-1:0]    q;
  logic [TAG_W-1:0] tag_d;

  thb_div_pipe #(.W(C-1), .TAG_W(TAG_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vs),
    .dist_val  (dist_val[C-2:0]),
    .radius    (brush_radius),
    .in_tag    (tag_s),
    .out_valid (vd),
    .ratio     (q),
    .out_tag   (tag_d)
  );

  // zero radius: full weight at the centre
  logic [TW-1:0] t;
  assign t = (brush_radius == '0) ? '0 : q;

  logic             vc;
  logic [WEIGHT_BITS:0] w;
  logic [TAG_W-1:0] tag_c;

  thb_cos_pipe #(.WEIGHT_BITS(WEIGHT_BITS), .TAG_W(TAG_W)) u_cos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vd),
    .ratio     (t),
    .in_tag    (tag_d),
    .out_valid (vc),
    .weight    (w),
    .out_tag   (tag_c)
  );

  // gain rank
  logic                    vg;
  logic [C-2:0]            dgain;
  logic [TAG_W-1:0]        tag_g;
  logic [C+WEIGHT_BITS-1:0] gprod;

  assign gprod = {{(WEIGHT_BITS+1){1'b0}}, step_gain} * {{(C-1){1'b0}}, w};

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dgain <= gprod[WEIGHT_BITS +: (C-1)];
      tag_g <= tag_c;
    end
  end

  // output rank: mode select, add or subtract, saturate, or zero in flat mode
  thb_flags_t          fl;
  logic signed [C-1:0] hg;
  logic [C-2:0]        delta;
  logic                touch;
  logic                zero;
  logic signed [C:0]   sum;
  logic signed [C-1:0] hnew;

  assign fl = tag_g[FLAGS_W-1:0];
  assign hg = tag_g[TAG_W-1:FLAGS_W];

  always_comb begin
    touch = 1'b0;
    zero  = 1'b0;
    delta = dgain;
    unique case (brush_mode)
      MODE_ROUND:  touch = fl.in_circle;
      MODE_SQUARE: begin
        touch = fl.in_square;
        delta = step_gain;
      end
      MODE_FLAT: begin
        touch = fl.in_circle;
        zero  = fl.in_circle;
      end
      default: ;
    endcase
    if (raise) begin
      sum = $signed({hg[C-1], hg}) + $signed({2'b00, delta});
    end else begin
      sum = $signed({hg[C-1], hg}) - $signed({2'b00, delta});
    end
    if (zero) begin
      hnew = '0;
    end else if (!touch) begin
      hnew = hg;
    end else if (sum[C] != sum[C-1]) begin
      hnew = sum[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    end else begin
      hnew = sum[C-1:0];
    end
  end

  logic rv;
  assign res.valid = rv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (en) begin
      rv <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.new_height <= hnew;
      res.touched    <= touch;
      res.sweep_end  <= fl.last;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !vtx.ready)
    else $error("input accepted while output stalled");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.touched && brush_mode == MODE_FLAT) |-> (res.new_height == '0))
    else $error("flatten mode left a nonzero height");

  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    (res.valid && brush_mode == MODE_UNUSED) |-> !res.touched)
    else $error("unused mode touched a vertex");

endmodule
`default_nettype wire

// ===== tb/brush_height_checker.sv =====
`timescale 1ns / 100ps
module brush_height_checker
  import thb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  thb_vtx_if   vtx,
  thb_res_if   res,
  thb_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  localparam longint HEIGHT_MAX = 64'sd8388607;
  localparam longint HEIGHT_MIN = -64'sd8388608;
  localparam longint DIFF_LIM   = 64'sd8388608;

  typedef struct {
    logic signed [23:0] height;
    logic               touched;
    logic               sweep_end;
  } brushed_t;

  brushed_t pending_heights[$];

  logic signed [23:0] center_x;
  logic signed [23:0] center_z;
  logic [22:0]        radius;
  logic [22:0]        gain;
  logic [1:0]         mode;
  logic               raise_on;

  function automatic longint isqrt(longint n);
    longint root;
    longint bit_w;
    root  = 0;
    bit_w = longint'(1) << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= root + bit_w) begin
        n    = n - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Q16 ratio in, Q1.16 cosine weight out
  function automatic longint cos_weight_q16(longint t);
    longint u;
    longint p;
    longint c;
    u = (t * t) >> 2;
    p = longint'(COS_C5);
    p = longint'(COS_C4) - ((u * p) >>> 30);
    p = longint'(COS_C3) - ((u * p) >>> 30);
    p = longint'(COS_C2) - ((u * p) >>> 30);
    p = longint'(COS_C1) - ((u * p) >>> 30);
    c = longint'(ONE_Q30) - ((u * p) >>> 30);
    if (c < 0) c = 0;
    return c >> 14;
  endfunction

  function automatic longint abs_sat(longint d);
    longint a;
    a = (d < 0) ? -d : d;
    return (a > DIFF_LIM) ? DIFF_LIM : a;
  endfunction

  function automatic brushed_t brushed_height(logic signed [23:0] x, logic signed [23:0] z,
                                              logic signed [23:0] h, logic last);
    brushed_t o;
    longint   ax;
    longint   az;
    longint   d2;
    longint   r;
    longint   t;
    longint   delta;
    longint   hh;
    logic     in_circle;
    logic     hit;
    logic     zero;
    ax        = abs_sat(longint'(x) - longint'(center_x));
    az        = abs_sat(longint'(z) - longint'(center_z));
    r         = longint'(radius);
    d2        = ax * ax + az * az;
    in_circle = (d2 <= r * r);
    hit       = 1'b0;
    zero      = 1'b0;
    delta     = 0;
    hh        = longint'(h);
    case (mode)
      MODE_ROUND: begin
        if (in_circle) begin
          hit = 1'b1;
          t   = 0;
          if (r != 0) begin
            t = (isqrt(d2) << 16) / r;
            if (t > 65536) t = 65536;
          end
          delta = (longint'(gain) * cos_weight_q16(t)) >> 16;
        end
      end
      MODE_SQUARE: begin
        if (ax <= r && az <= r) begin
          hit   = 1'b1;
          delta = longint'(gain);
        end
      end
      MODE_FLAT: begin
        if (in_circle) begin
          hit  = 1'b1;
          zero = 1'b1;
        end
      end
      default: ;
    endcase
    if (zero) begin
      hh = 0;
    end else if (hit) begin
      hh = raise_on ? hh + delta : hh - delta;
      if (hh > HEIGHT_MAX) hh = HEIGHT_MAX;
      if (hh < HEIGHT_MIN) hh = HEIGHT_MIN;
    end
    o.height    = hh[23:0];
    o.touched   = hit;
    o.sweep_end = last;
    return o;
  endfunction

  always @(posedge clk) begin
    brushed_t want;
    if (rst) begin
      center_x = '0;
      center_z = '0;
      radius   = 23'd4096;
      gain     = '0;
      mode     = MODE_ROUND;
      raise_on = 1'b1;
      pending_heights.delete();
      errors   = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_CENTER_X: center_x = cfg.data;
          CFG_CENTER_Z: center_z = cfg.data;
          CFG_RADIUS:   radius   = cfg.data[22:0];
          CFG_GAIN:     gain     = cfg.data[22:0];
          CFG_MODE:     mode     = cfg.data[1:0];
          CFG_RAISE:    raise_on = cfg.data[0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (pending_heights.size() == 0) begin
          $error("result word with no vertex outstanding");
          errors++;
        end else begin
          want = pending_heights.pop_front();
          if (res.new_height !== want.height) begin
            $error("new_height: expected %0d, got %0d", want.height, res.new_height);
            errors++;
          end
          if (res.touched !== want.touched) begin
            $error("touched: expected %0b, got %0b", want.touched, res.touched);
            errors++;
          end
          if (res.sweep_end !== want.sweep_end) begin
            $error("sweep_end: expected %0b, got %0b", want.sweep_end, res.sweep_end);
            errors++;
          end
        end
      end
      if (vtx.valid && vtx.ready)
        pending_heights.push_back(brushed_height(vtx.vertex_x, vtx.vertex_z,
                                                 vtx.vertex_height, vtx.last_vertex));
    end
    pending = pending_heights.size();
  end

endmodule

// ===== tb/tb_terrain_height_brush_top.sv =====
`timescale 1ns / 100ps
module tb_terrain_height_brush_top;
  import thb_pkg::*;

  localparam int          IDLE_LIMIT  = 5000;
  localparam int          PIPE_FLUSH  = 64;
  localparam logic [23:0] COORD_MAX   = 24'h7fffff;
  localparam logic [23:0] COORD_MIN   = 24'h800000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_cycles;
  int   stall_left;
  bit   steady;
  logic [22:0] cur_radius;
  logic [23:0] cur_cx;
  logic [23:0] cur_cz;

  thb_vtx_if vtx ();
  thb_res_if res ();
  thb_cfg_if cfg ();

  terrain_height_brush_top uut (
    .clk(clk),
    .rst(rst),
    .vtx(vtx),
    .res(res),
    .cfg(cfg)
  );

  brush_height_checker checker_i (
    .clk(clk),
    .rst(rst),
    .vtx(vtx),
    .res(res),
    .cfg(cfg),
    .errors(errors),
    .pending(pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random result-side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res.ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res.ready  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (vtx.valid && vtx.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
    cfg.index <= idx;
    cfg.data  <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  task automatic set_brush(logic [23:0] cx, logic [23:0] cz, logic [22:0] radius,
                           logic [22:0] gain, logic [1:0] mode, logic up);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, {1'b0, radius});
    write_reg(CFG_GAIN, {1'b0, gain});
    write_reg(CFG_MODE, {22'd0, mode});
    write_reg(CFG_RAISE, {23'd0, up});
    cur_radius = radius;
    cur_cx     = cx;
    cur_cz     = cz;
  endtask

  task automatic send_vertex(logic [23:0] x, logic [23:0] z, logic [23:0] h, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx.valid         <= 1'b1;
    vtx.vertex_x      <= x;
    vtx.vertex_z      <= z;
    vtx.vertex_height <= h;
    vtx.last_vertex   <= last;
    do @(posedge clk); while (!vtx.ready);
  endtask

  // drop valid and let the pipeline empty before touching registers
  task automatic drain();
    vtx.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  function automatic logic [23:0] near_coord(logic [23:0] c);
    longint span;
    longint v;
    span = longint'(cur_radius) + longint'(cur_radius) / 4 + 4;
    if (span > 64'sd8000000) span = 64'sd8000000;
    v = longint'($signed(c)) + longint'($urandom_range(0, 32'(2 * span))) - span;
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  function automatic logic [23:0] rand_height();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 24'(COORD_MAX - $urandom_range(0, 3000));
    if (roll == 1) return 24'(COORD_MIN + $urandom_range(0, 3000));
    return 24'($urandom());
  endfunction

  function automatic logic [22:0] rand_radius();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return 23'h7fffff;
    if (roll < 5) return 23'($urandom_range(0, 256));
    return 23'($urandom_range(256, 65536));
  endfunction

  function automatic logic [22:0] rand_gain();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return 23'h7fffff;
    if (roll == 2) return 23'($urandom());
    return 23'($urandom_range(1, 65536));
  endfunction

  function automatic logic [23:0] rand_center();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return COORD_MAX;
    if (roll == 2) return COORD_MIN;
    if (roll < 5) return 24'($urandom());
    return 24'($urandom_range(0, 200000) - 100000);
  endfunction

  initial begin
    logic [1:0] mode;
    rst               <= 1'b1;
    steady             = 1'b0;
    vtx.valid         <= 1'b0;
    vtx.vertex_x      <= '0;
    vtx.vertex_z      <= '0;
    vtx.vertex_height <= '0;
    vtx.last_vertex   <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= CFG_CENTER_X;
    cfg.data          <= '0;
    cur_radius         = 23'd4096;
    cur_cx             = '0;
    cur_cz             = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: unit radius, zero gain
    send_vertex(24'd0, 24'd0, 24'd1234, 1'b0);
    send_vertex(24'd4096, 24'd0, 24'd77, 1'b1);
    drain();

    set_brush(24'd0, 24'd0, 23'd4096, 23'd4096, MODE_ROUND, 1'b1);
    send_vertex(24'd0, 24'd0, 24'd0, 1'b0);
    send_vertex(24'd4096, 24'd0, 24'd0, 1'b0);
    send_vertex(-24'sd4096, 24'd0, 24'd0, 1'b0);
    send_vertex(24'd4097, 24'd0, 24'd0, 1'b0);
    send_vertex(24'd2048, 24'd2048, 24'd0, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(24'd0, 24'd100, COORD_MAX, 1'b1);
    drain();

    set_brush(24'd1000, -24'sd1000, 23'd4096, 23'h7fffff, MODE_SQUARE, 1'b0);
    send_vertex(24'd5096, -24'sd5096, COORD_MIN, 1'b0);
    send_vertex(24'd5097, 24'd0, 24'd5, 1'b0);
    send_vertex(24'd1000, -24'sd1000, 24'd0, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 24'd0, 1'b1);
    drain();

    set_brush(COORD_MAX, COORD_MIN, 23'd100, 23'd50, MODE_FLAT, 1'b1);
    send_vertex(COORD_MAX, COORD_MIN, 24'h123456, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 24'h123456, 1'b0);
    send_vertex(COORD_MAX - 24'd100, COORD_MIN, COORD_MIN, 1'b1);
    drain();

    set_brush(24'd0, 24'd0, 23'h7fffff, 23'h7fffff, MODE_UNUSED, 1'b1);
    send_vertex(24'd0, 24'd0, 24'h654321, 1'b0);
    send_vertex(24'd10, 24'd10, COORD_MAX, 1'b1);
    drain();

    // zero radius: only the exact centre is hit, with full gain
    set_brush(24'd300, 24'd300, 23'd0, 23'd9000, MODE_ROUND, 1'b1);
    send_vertex(24'd300, 24'd300, 24'd1, 1'b0);
    send_vertex(24'd301, 24'd300, 24'd1, 1'b0);
    send_vertex(24'd300, 24'd299, 24'd1, 1'b1);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      mode = ($urandom_range(0, 7) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
      set_brush(rand_center(), rand_center(), rand_radius(), rand_gain(), mode,
                1'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 55; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_vertex(24'($urandom()), 24'($urandom()), 24'($urandom()),
                      1'($urandom_range(0, 1)));
        else
          send_vertex(near_coord(cur_cx), near_coord(cur_cz), rand_height(),
                      n == 54);
      end
      steady = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
